### rtl/sha1sh_pkg.sv
`default_nettype none
package sha1sh_pkg;

  localparam int unsigned NUM_WORDS   = 5;
  localparam int unsigned BLOCK_WORDS = 16;
  localparam int unsigned BLOCK_BYTES = 64;
  localparam int unsigned LEN_LIMIT   = 56;  // first byte slot of the length field
  localparam int unsigned ROUNDS      = 80;

  localparam logic [7:0] PAD_BYTE      = 8'h80;
  localparam logic [2:0] LAST_WORD_IDX = 3'd4;

  localparam logic [31:0] IV_WORD [NUM_WORDS] = '{
    32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
  };

  localparam logic [31:0] K_00_19 = 32'h5a827999;
  localparam logic [31:0] K_20_39 = 32'h6ed9eba1;
  localparam logic [31:0] K_40_59 = 32'h8f1bbcdc;
  localparam logic [31:0] K_60_79 = 32'hca62c1d6;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       byte_present;
    logic       end_of_message;
  } sha_in_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;
  } sha_out_t;

  function automatic logic [31:0] rotl(input logic [31:0] x, input int unsigned n);
    rotl = (x << n) | (x >> (32 - n));
  endfunction

endpackage
`default_nettype wire

### rtl/sha1_stream_hasher.sv
`default_nettype none
// Channel  | Direction | Handshake               | Payload
// in_      | input     | in_valid / in_ready     | sha_in_t  (byte, present, end)
// out_     | output    | out_valid / out_ready   | sha_out_t (word, index, last)
//
// A beat with a byte stores it in the block. The beat that fills the 64th byte adds one
// compression (load, 80 rounds on the shared round adder, fold-in).
// An end beat adds a step for the 0x80 byte, one for the length, one or two
// compressions, then five output beats; in_ready stays low throughout.
// Reset (rst_n low, synchronous) loads the initial hash values and clears the
// block, fill count and bit length. A stalled out_ready holds the current word.
module sha1_stream_hasher (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire sha1sh_pkg::sha_in_t  in_data,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output sha1sh_pkg::sha_out_t      out_data
);
  import sha1sh_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,   // take byte / end beats
    ST_PAD,    // place the 0x80 marker
    ST_LEN,    // place the 64-bit bit length
    ST_INIT,   // load working variables
    ST_ROUND,  // one round per cycle
    ST_FINAL,  // fold into chain, clear block
    ST_EMIT    // drive the five digest words
  } state_t;

  state_t       state_r, state_nxt;
  state_t       ret_r, ret_nxt;     // where to go once a compression ends
  logic [6:0]   fill_r, fill_nxt;
  logic [63:0]  bits_r, bits_nxt;
  logic [6:0]   round_r, round_nxt;
  logic [2:0]   widx_r, widx_nxt;
  logic [31:0]  chain_r [NUM_WORDS];
  logic [31:0]  chain_nxt [NUM_WORDS];
  logic [31:0]  store_r [BLOCK_WORDS];
  logic [31:0]  store_nxt [BLOCK_WORDS];
  logic [31:0]  a_r, b_r, c_r, d_r, e_r;
  logic [31:0]  a_nxt, b_nxt, c_nxt, d_nxt, e_nxt;

  logic         in_fire, out_fire;
  logic [6:0]   fill_inc;
  logic [4:0]   lane_sh;
  logic [31:0]  f_val, k_val, w_new, round_sum;

  assign in_fire   = in_valid && in_ready;
  assign out_fire  = out_valid && out_ready;
  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = (state_r == ST_EMIT);

  assign out_data.digest_word = chain_r[widx_r];
  assign out_data.word_index  = widx_r;
  assign out_data.last_word   = (widx_r == LAST_WORD_IDX);

  assign fill_inc = fill_r + 7'd1;
  // Big-endian byte lane: slot 0 of a word sits in bits 31:24.
  assign lane_sh  = {~fill_r[1:0], 3'b000};

  // Round function and constant per 20-round stage.
  always_comb begin
    if (round_r < 7'd20) begin
      f_val = (b_r & c_r) | (~b_r & d_r);
      k_val = K_00_19;
    end else if (round_r < 7'd40) begin
      f_val = b_r ^ c_r ^ d_r;
      k_val = K_20_39;
    end else if (round_r < 7'd60) begin
      f_val = (b_r & c_r) | (b_r & d_r) | (c_r & d_r);
      k_val = K_40_59;
    end else begin
      f_val = b_r ^ c_r ^ d_r;
      k_val = K_60_79;
    end
  end

  // The block store doubles as the 16-word schedule window: word 0 is W[t].
  assign w_new     = rotl(store_r[13] ^ store_r[8] ^ store_r[2] ^ store_r[0], 1);
  assign round_sum = rotl(a_r, 5) + f_val + e_r + k_val + store_r[0];

  always_comb begin
    state_nxt = state_r;
    ret_nxt   = ret_r;
    fill_nxt  = fill_r;
    bits_nxt  = bits_r;
    round_nxt = round_r;
    widx_nxt  = widx_r;
    chain_nxt = chain_r;
    store_nxt = store_r;
    a_nxt = a_r;
    b_nxt = b_r;
    c_nxt = c_r;
    d_nxt = d_r;
    e_nxt = e_r;

    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          if (in_data.byte_present) begin
            store_nxt[fill_r[5:2]][lane_sh +: 8] = in_data.data_byte;
            fill_nxt = fill_inc;
            bits_nxt = bits_r + 64'd8;
            if (fill_inc == 7'(BLOCK_BYTES)) begin
              state_nxt = ST_INIT;
              ret_nxt   = in_data.end_of_message ? ST_PAD : ST_IDLE;
            end else if (in_data.end_of_message) begin
              state_nxt = ST_PAD;
            end
          end else if (in_data.end_of_message) begin
            state_nxt = ST_PAD;
          end
        end
      end

      ST_PAD: begin
        store_nxt[fill_r[5:2]][lane_sh +: 8] = PAD_BYTE;
        fill_nxt = fill_inc;
        // No room left for the length: compress this block first.
        if (fill_inc > 7'(LEN_LIMIT)) begin
          state_nxt = ST_INIT;
          ret_nxt   = ST_LEN;
        end else begin
          state_nxt = ST_LEN;
        end
      end

      ST_LEN: begin
        store_nxt[BLOCK_WORDS-2] = bits_r[63:32];
        store_nxt[BLOCK_WORDS-1] = bits_r[31:0];
        state_nxt = ST_INIT;
        ret_nxt   = ST_EMIT;
      end

      ST_INIT: begin
        a_nxt = chain_r[0];
        b_nxt = chain_r[1];
        c_nxt = chain_r[2];
        d_nxt = chain_r[3];
        e_nxt = chain_r[4];
        round_nxt = '0;
        state_nxt = ST_ROUND;
      end

      ST_ROUND: begin
        a_nxt = round_sum;
        b_nxt = a_r;
        c_nxt = rotl(b_r, 30);
        d_nxt = c_r;
        e_nxt = d_r;
        for (int i = 0; i < BLOCK_WORDS - 1; i++) begin
          store_nxt[i] = store_r[i+1];
        end
        store_nxt[BLOCK_WORDS-1] = w_new;
        round_nxt = round_r + 7'd1;
        if (round_r == 7'(ROUNDS - 1)) begin
          state_nxt = ST_FINAL;
        end
      end

      ST_FINAL: begin
        chain_nxt[0] = chain_r[0] + a_r;
        chain_nxt[1] = chain_r[1] + b_r;
        chain_nxt[2] = chain_r[2] + c_r;
        chain_nxt[3] = chain_r[3] + d_r;
        chain_nxt[4] = chain_r[4] + e_r;
        for (int i = 0; i < BLOCK_WORDS; i++) begin
          store_nxt[i] = '0;
        end
        fill_nxt  = '0;
        widx_nxt  = '0;
        state_nxt = ret_r;
      end

      ST_EMIT: begin
        if (out_fire) begin
          if (widx_r == LAST_WORD_IDX) begin
            // Restart for the next message.
            for (int i = 0; i < NUM_WORDS; i++) begin
              chain_nxt[i] = IV_WORD[i];
            end
            bits_nxt  = '0;
            widx_nxt  = '0;
            state_nxt = ST_IDLE;
          end else begin
            widx_nxt = widx_r + 3'd1;
          end
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    a_r     <= a_nxt;
    b_r     <= b_nxt;
    c_r     <= c_nxt;
    d_r     <= d_nxt;
    e_r     <= e_nxt;
    round_r <= round_nxt;
    if (!rst_n) begin
      state_r <= ST_IDLE;
      ret_r   <= ST_IDLE;
      fill_r  <= '0;
      bits_r  <= '0;
      widx_r  <= '0;
      for (int i = 0; i < NUM_WORDS; i++) begin
        chain_r[i] <= IV_WORD[i];
      end
      for (int i = 0; i < BLOCK_WORDS; i++) begin
        store_r[i] <= '0;
      end
    end else begin
      state_r <= state_nxt;
      ret_r   <= ret_nxt;
      fill_r  <= fill_nxt;
      bits_r  <= bits_nxt;
      widx_r  <= widx_nxt;
      chain_r <= chain_nxt;
      store_r <= store_nxt;
    end
  end

  // The two sides never run at once.
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid))
    else $error("input and output active together");

  // A closing beat holds off further input.
  a_end_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && in_data.end_of_message) |=> !in_ready)
    else $error("ready after end of message");

  // Every compression leaves an empty block.
  a_fold_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FINAL) |=> (fill_r == 7'd0 && store_r[0] == 32'd0))
    else $error("block not cleared after compression");

  // The final word restarts the hash state.
  a_restart: assert property (@(posedge clk) disable iff (!rst_n)
    (out_fire && out_data.last_word) |=>
      (bits_r == 64'd0 && chain_r[0] == IV_WORD[0] && in_ready))
    else $error("hash state not restarted");

endmodule
`default_nettype wire
